>>> sv/aru_pkg.sv
// Shared types, constants and helper functions for the adaptive row unfilter.
package aru_pkg;

    localparam int MAX_ROW_BYTES   = 8192;
    localparam int MAX_PIXEL_BYTES = 8;

    localparam int COL_W   = $clog2(MAX_ROW_BYTES);
    localparam int LEN_W   = 14;
    localparam int ROWS_W  = 16;
    localparam int BPP_W   = 4;
    localparam int HIST_W  = $clog2(MAX_PIXEL_BYTES);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W = CMDQ_PTR_W + 1;

    localparam int OUTQ_DEPTH = 2;
    localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CNT_W = OUTQ_PTR_W + 1;

    localparam logic [LEN_W-1:0]  MAX_LEN = LEN_W'(MAX_ROW_BYTES);
    localparam logic [BPP_W-1:0]  MAX_BPP = BPP_W'(MAX_PIXEL_BYTES);
    localparam logic [7:0]        MAX_FILTER_CODE = 8'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PIXEL_BYTES = 2'd0,
        CFG_ROW_BYTES   = 2'd1,
        CFG_ROW_COUNT   = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        FILT_NONE  = 3'd0,
        FILT_SUB   = 3'd1,
        FILT_UP    = 3'd2,
        FILT_AVG   = 3'd3,
        FILT_PAETH = 3'd4
    } t_filter;

    typedef struct packed {
        logic             is_err;
        logic [COL_W-1:0] col;
        t_filter          filter;
        logic             first_row;
        logic             eor;
        logic             eoi;
        logic             sticky;
        logic [7:0]       data;
    } t_cmd;

    typedef struct packed {
        logic [7:0] pixel;
        logic       eor;
        logic       eoi;
        logic       err;
    } t_res;

    function automatic logic [9:0] abs11(input logic signed [10:0] v);
        logic signed [10:0] neg;
        neg = -v;
        return v[10] ? neg[9:0] : v[9:0];
    endfunction

    function automatic logic [7:0] paeth_pick(input logic [7:0] a,
                                              input logic [7:0] b,
                                              input logic [7:0] c);
        logic signed [10:0] da;
        logic signed [10:0] db;
        logic signed [10:0] dc;
        logic [9:0] pa;
        logic [9:0] pb;
        logic [9:0] pc;
        da = $signed({3'b000, b}) - $signed({3'b000, c});
        db = $signed({3'b000, a}) - $signed({3'b000, c});
        dc = $signed({3'b000, a}) + $signed({3'b000, b}) - $signed({2'b00, c, 1'b0});
        pa = abs11(da);
        pb = abs11(db);
        pc = abs11(dc);
        if (pa <= pb && pa <= pc) begin
            return a;
        end else if (pb <= pc) begin
            return b;
        end
        return c;
    endfunction

endpackage

>>> sv/aru_front.sv
// Front end: row framing, filter type decode and command generation.
module aru_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  logic                         i_full,
    input  logic [7:0]                   i_byte,
    input  logic [aru_pkg::LEN_W-1:0]    i_row_bytes,
    input  logic [aru_pkg::ROWS_W-1:0]   i_row_count,
    output aru_pkg::t_cmd                o_cmd,
    output logic                         o_cmd_push
);

    logic                        r_await;
    logic                        n_await;
    logic [aru_pkg::COL_W-1:0]   r_col;
    logic [aru_pkg::COL_W-1:0]   n_col;
    logic [aru_pkg::ROWS_W-1:0]  r_row;
    logic [aru_pkg::ROWS_W-1:0]  n_row;
    aru_pkg::t_filter            r_filter;
    aru_pkg::t_filter            n_filter;
    logic                        r_err;
    logic                        n_err;

    logic                        accept;
    logic [aru_pkg::LEN_W-1:0]   len;
    logic [aru_pkg::ROWS_W-1:0]  rows;
    logic [aru_pkg::COL_W-1:0]   col_eff;
    logic [aru_pkg::LEN_W-1:0]   col_next;
    logic [aru_pkg::ROWS_W:0]    row_next;
    logic                        eor;
    logic                        eoi;
    logic                        bad_type;

    assign accept = i_push && !i_full;

    always_comb begin
        if (i_row_bytes == '0) begin
            len = aru_pkg::LEN_W'(1);
        end else if (i_row_bytes > aru_pkg::MAX_LEN) begin
            len = aru_pkg::MAX_LEN;
        end else begin
            len = i_row_bytes;
        end
        rows = (i_row_count == '0) ? aru_pkg::ROWS_W'(1) : i_row_count;
        if ({1'b0, r_col} >= len) begin
            col_eff = aru_pkg::COL_W'(len - aru_pkg::LEN_W'(1));
        end else begin
            col_eff = r_col;
        end
        col_next = {1'b0, col_eff} + aru_pkg::LEN_W'(1);
        row_next = {1'b0, r_row} + (aru_pkg::ROWS_W + 1)'(1);
        eor      = col_next >= len;
        eoi      = eor && (row_next >= {1'b0, rows});
        bad_type = i_byte > aru_pkg::MAX_FILTER_CODE;
    end

    always_comb begin
        n_await  = r_await;
        n_col    = r_col;
        n_row    = r_row;
        n_filter = r_filter;
        n_err    = r_err;
        o_cmd_push = 1'b0;
        o_cmd.is_err    = 1'b0;
        o_cmd.col       = col_eff;
        o_cmd.filter    = r_filter;
        o_cmd.first_row = r_row == '0;
        o_cmd.eor       = eor;
        o_cmd.eoi       = eoi;
        o_cmd.sticky    = r_err;
        o_cmd.data      = i_byte;
        if (accept) begin
            if (r_await) begin
                n_await = 1'b0;
                n_col   = '0;
                if (bad_type) begin
                    n_err        = 1'b1;
                    n_filter     = aru_pkg::FILT_NONE;
                    o_cmd_push   = 1'b1;
                    o_cmd.is_err = 1'b1;
                    o_cmd.eor    = 1'b0;
                    o_cmd.eoi    = 1'b0;
                    o_cmd.sticky = 1'b1;
                end else begin
                    n_filter = aru_pkg::t_filter'(i_byte[2:0]);
                end
            end else begin
                o_cmd_push = 1'b1;
                if (eor) begin
                    n_col   = '0;
                    n_await = 1'b1;
                    n_row   = eoi ? '0 : row_next[aru_pkg::ROWS_W-1:0];
                end else begin
                    n_col = col_next[aru_pkg::COL_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_await  <= 1'b1;
            r_col    <= '0;
            r_row    <= '0;
            r_filter <= aru_pkg::FILT_NONE;
            r_err    <= 1'b0;
        end else begin
            r_await  <= n_await;
            r_col    <= n_col;
            r_row    <= n_row;
            r_filter <= n_filter;
            r_err    <= n_err;
        end
    end

endmodule

>>> sv/aru_cmd_queue.sv
// Short command queue between front end and back end.
module aru_cmd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  aru_pkg::t_cmd  i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output aru_pkg::t_cmd  o_cmd,
    output logic           o_valid
);

    aru_pkg::t_cmd                   r_entry [aru_pkg::CMDQ_DEPTH];
    logic [aru_pkg::CMDQ_PTR_W-1:0]  r_wr_ptr;
    logic [aru_pkg::CMDQ_PTR_W-1:0]  r_rd_ptr;
    logic [aru_pkg::CMDQ_CNT_W-1:0]  r_count;
    logic                            do_push;
    logic                            do_pop;

    assign o_full  = r_count == aru_pkg::CMDQ_CNT_W'(aru_pkg::CMDQ_DEPTH);
    assign o_valid = r_count != '0;
    assign o_cmd   = r_entry[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + aru_pkg::CMDQ_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + aru_pkg::CMDQ_PTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + aru_pkg::CMDQ_CNT_W'(1);
                2'b01:   r_count <= r_count - aru_pkg::CMDQ_CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> sv/aru_back.sv
// Back end: above-row memory, neighbour history, prediction and result buffer.
module aru_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [aru_pkg::BPP_W-1:0]   i_pixel_bytes,
    input  aru_pkg::t_cmd               i_cmd,
    input  logic                        i_cmd_valid,
    output logic                        o_cmd_pop,
    output logic                        o_empty,
    input  logic                        i_pop,
    output aru_pkg::t_res               o_res
);

    logic [7:0]                      r_above_row [aru_pkg::MAX_ROW_BYTES];
    logic [7:0]                      r_mem_q;
    logic                            r_byp;
    logic [7:0]                      r_byp_data;
    logic [7:0]                      r_left [aru_pkg::MAX_PIXEL_BYTES];
    logic [7:0]                      r_abv_hist [aru_pkg::MAX_PIXEL_BYTES];
    aru_pkg::t_cmd                   r_b2;
    logic                            r_b2_valid;
    aru_pkg::t_res                   r_outq [aru_pkg::OUTQ_DEPTH];
    logic [aru_pkg::OUTQ_PTR_W-1:0]  r_out_wr;
    logic [aru_pkg::OUTQ_PTR_W-1:0]  r_out_rd;
    logic [aru_pkg::OUTQ_CNT_W-1:0]  r_out_count;

    logic [aru_pkg::BPP_W-1:0]   bpp;
    logic [aru_pkg::HIST_W-1:0]  hist_idx;
    logic                        has_left;
    logic [7:0]                  a;
    logic [7:0]                  b;
    logic [7:0]                  c;
    logic [8:0]                  ab_sum;
    logic [7:0]                  pred;
    logic [7:0]                  val;
    logic                        retire;
    logic                        adv;
    logic                        wr;
    logic                        out_pop;
    aru_pkg::t_res               res;

    always_comb begin
        if (i_pixel_bytes == '0) begin
            bpp = aru_pkg::BPP_W'(1);
        end else if (i_pixel_bytes > aru_pkg::MAX_BPP) begin
            bpp = aru_pkg::MAX_BPP;
        end else begin
            bpp = i_pixel_bytes;
        end
        hist_idx = aru_pkg::HIST_W'(bpp - aru_pkg::BPP_W'(1));
        has_left = r_b2.col >= aru_pkg::COL_W'(bpp);
        b = r_b2.first_row ? 8'd0 : (r_byp ? r_byp_data : r_mem_q);
        a = has_left ? r_left[hist_idx] : 8'd0;
        c = (has_left && !r_b2.first_row) ? r_abv_hist[hist_idx] : 8'd0;
        ab_sum = {1'b0, a} + {1'b0, b};
        case (r_b2.filter)
            aru_pkg::FILT_SUB:   pred = a;
            aru_pkg::FILT_UP:    pred = b;
            aru_pkg::FILT_AVG:   pred = ab_sum[8:1];
            aru_pkg::FILT_PAETH: pred = aru_pkg::paeth_pick(a, b, c);
            default:             pred = 8'd0;
        endcase
        val = r_b2.data + pred;
        if (r_b2.is_err) begin
            res.pixel = 8'd0;
            res.eor   = 1'b0;
            res.eoi   = 1'b0;
            res.err   = 1'b1;
        end else begin
            res.pixel = r_b2.sticky ? 8'd0 : val;
            res.eor   = r_b2.eor;
            res.eoi   = r_b2.eoi;
            res.err   = r_b2.sticky;
        end
    end

    assign retire    = r_b2_valid &&
                       (r_out_count != aru_pkg::OUTQ_CNT_W'(aru_pkg::OUTQ_DEPTH));
    assign adv       = !r_b2_valid || retire;
    assign o_cmd_pop = adv && i_cmd_valid;
    assign wr        = retire && !r_b2.is_err;
    assign out_pop   = i_pop && !o_empty;
    assign o_empty   = r_out_count == '0;
    assign o_res     = r_outq[r_out_rd];

    // above-row store; a write to the column being read is forwarded
    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_above_row[r_b2.col] <= val;
        end
        if (o_cmd_pop) begin
            r_mem_q    <= r_above_row[i_cmd.col];
            r_byp      <= wr && (r_b2.col == i_cmd.col);
            r_byp_data <= val;
            r_b2       <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            for (int i = aru_pkg::MAX_PIXEL_BYTES - 1; i > 0; i--) begin
                r_left[i]     <= r_left[i-1];
                r_abv_hist[i] <= r_abv_hist[i-1];
            end
            r_left[0]     <= val;
            r_abv_hist[0] <= b;
        end
        if (retire) begin
            r_outq[r_out_wr] <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b2_valid  <= 1'b0;
            r_out_wr    <= '0;
            r_out_rd    <= '0;
            r_out_count <= '0;
        end else begin
            if (adv) begin
                r_b2_valid <= i_cmd_valid;
            end
            if (retire) begin
                r_out_wr <= r_out_wr + aru_pkg::OUTQ_PTR_W'(1);
            end
            if (out_pop) begin
                r_out_rd <= r_out_rd + aru_pkg::OUTQ_PTR_W'(1);
            end
            case ({retire, out_pop})
                2'b10:   r_out_count <= r_out_count + aru_pkg::OUTQ_CNT_W'(1);
                2'b01:   r_out_count <= r_out_count - aru_pkg::OUTQ_CNT_W'(1);
                default: r_out_count <= r_out_count;
            endcase
        end
    end

endmodule

>>> sv/adaptive_row_unfilter_unit.sv
// A data beat passes through the command queue, the back-end stage register and the result queue before it is poppable.
// One beat per cycle while the command queue is not full; the back end predicts and adds combinationally.
// Valid type beats yield no result; invalid type beats yield one error result.
// Reset: synchronous, active low; clears framing, queues and config to their defaults.
// The above-row memory is not cleared.
module adaptive_row_unfilter_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic [7:0]                       i_filtered_byte,
    output logic                             empty,
    input  logic                             pop,
    output logic [7:0]                       o_pixel_byte,
    output logic                             o_end_of_row,
    output logic                             o_end_of_image,
    output logic                             o_error,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [aru_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [aru_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    logic [aru_pkg::BPP_W-1:0]   r_pixel_bytes;
    logic [aru_pkg::LEN_W-1:0]   r_row_bytes;
    logic [aru_pkg::ROWS_W-1:0]  r_row_count;

    aru_pkg::t_cmd  front_cmd;
    logic           front_push;
    aru_pkg::t_cmd  q_cmd;
    logic           q_valid;
    logic           q_pop;
    aru_pkg::t_res  res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_bytes <= aru_pkg::BPP_W'(1);
            r_row_bytes   <= aru_pkg::LEN_W'(1);
            r_row_count   <= aru_pkg::ROWS_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (aru_pkg::t_cfg_idx'(i_cfg_index))
                aru_pkg::CFG_PIXEL_BYTES: r_pixel_bytes <= i_cfg_data[aru_pkg::BPP_W-1:0];
                aru_pkg::CFG_ROW_BYTES:   r_row_bytes   <= i_cfg_data[aru_pkg::LEN_W-1:0];
                aru_pkg::CFG_ROW_COUNT:   r_row_count   <= i_cfg_data[aru_pkg::ROWS_W-1:0];
                default: ;
            endcase
        end
    end

    aru_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_full      (full),
        .i_byte      (i_filtered_byte),
        .i_row_bytes (r_row_bytes),
        .i_row_count (r_row_count),
        .o_cmd       (front_cmd),
        .o_cmd_push  (front_push)
    );

    aru_cmd_queue u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_cmd   (front_cmd),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_cmd   (q_cmd),
        .o_valid (q_valid)
    );

    aru_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pixel_bytes (r_pixel_bytes),
        .i_cmd         (q_cmd),
        .i_cmd_valid   (q_valid),
        .o_cmd_pop     (q_pop),
        .o_empty       (empty),
        .i_pop         (pop),
        .o_res         (res)
    );

    assign o_pixel_byte   = res.pixel;
    assign o_end_of_row   = res.eor;
    assign o_end_of_image = res.eoi;
    assign o_error        = res.err;

endmodule
